// ===== src/ocf_pkg.sv =====
// ocf_pkg: sizes, operation and status codes, write-port structs and helpers
// for the owner-checked FIFO.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package ocf_pkg;

    // Queue geometry
    localparam int DEPTH   = 64;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int OCC_W   = $clog2(DEPTH + 1);

    // Item fields
    localparam int OP_W     = 2;
    localparam int OWNER_W  = 7;
    localparam int OWNERS   = 2 ** OWNER_W;
    localparam int VALUE_W  = 64;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 7;

    // Stream data widths, rounded up to whole bytes
    localparam int IN_FIELDS_W  = OP_W + OWNER_W + VALUE_W;
    localparam int OUT_FIELDS_W = STATUS_W + VALUE_W + CNT_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_NOT_OWNER = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    // Entry store write port
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [OWNER_W-1:0] owner;
        logic [VALUE_W-1:0] value;
    } t_entry_wr;

    // Per-owner count write port
    typedef struct packed {
        logic               en;
        logic [OWNER_W-1:0] addr;
        logic [CNT_W-1:0]   data;
    } t_cnt_wr;

    // Ring index advance with wrap at DEPTH
    function automatic logic [IDX_W-1:0] f_next_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] nxt;
        nxt = (idx == IDX_W'(DEPTH - 1)) ? '0 : idx + 1'b1;
        return nxt;
    endfunction

endpackage

// ===== src/ocf_entry_store.sv =====
// ocf_entry_store: owner tag and value storage of the queue entries.
// One write port, one registered read port with write-through on collision.
// Depends on ocf_pkg.
`timescale 1ns / 1ps

module ocf_entry_store (
    input  logic                         i_clk,
    input  ocf_pkg::t_entry_wr           i_wr,
    input  logic [ocf_pkg::IDX_W-1:0]    i_rd_addr,
    output logic [ocf_pkg::OWNER_W-1:0]  o_rd_owner,
    output logic [ocf_pkg::VALUE_W-1:0]  o_rd_value
);
    import ocf_pkg::*;

    logic [OWNER_W-1:0] r_entry_owner [DEPTH];
    logic [VALUE_W-1:0] r_entry_value [DEPTH];
    logic [OWNER_W-1:0] r_rd_owner;
    logic [VALUE_W-1:0] r_rd_value;

    // Write at the tail slot
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_entry_owner[i_wr.addr] <= i_wr.owner;
            r_entry_value[i_wr.addr] <= i_wr.value;
        end
    end

    // Registered read; a same-cycle write to the read slot is passed through
    always_ff @(posedge i_clk) begin
        if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
            r_rd_owner <= i_wr.owner;
            r_rd_value <= i_wr.value;
        end else begin
            r_rd_owner <= r_entry_owner[i_rd_addr];
            r_rd_value <= r_entry_value[i_rd_addr];
        end
    end

    assign o_rd_owner = r_rd_owner;
    assign o_rd_value = r_rd_value;

endmodule

// ===== src/ocf_count_store.sv =====
// ocf_count_store: queued-entry count for each owner.
// Memory with one valid bit per owner; an owner never written reads as zero.
// Depends on ocf_pkg.
`timescale 1ns / 1ps

module ocf_count_store (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rd_en,
    input  logic [ocf_pkg::OWNER_W-1:0]  i_rd_addr,
    input  ocf_pkg::t_cnt_wr             i_wr,
    output logic [ocf_pkg::CNT_W-1:0]    o_rd_count
);
    import ocf_pkg::*;

    logic [CNT_W-1:0]  r_count [OWNERS];
    logic [OWNERS-1:0] r_valid;
    logic [CNT_W-1:0]  r_rd_data;
    logic              r_rd_vld;

    // Count memory write
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_count[i_wr.addr] <= i_wr.data;
        end
    end

    // Valid bits and read-valid flag, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= (i_wr.en && (i_wr.addr == i_rd_addr)) ? 1'b1
                                                                  : r_valid[i_rd_addr];
            end
        end
    end

    // Registered read with write-through on collision
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else begin
                r_rd_data <= r_count[i_rd_addr];
            end
        end
    end

    assign o_rd_count = r_rd_vld ? r_rd_data : '0;

endmodule

// ===== src/owner_checked_fifo.sv =====
// Owner-checked FIFO: a 64-entry queue of (owner, value) entries with a
// per-owner count of queued entries. Add appends or reports full, remove pops
// the head only if its owner matches and returns its value, query reports the
// owner's count (code 3 acts as a query). One transaction is accepted every
// clock cycle while the output drains. A transaction executes while held in
// the input register and commits when it moves on into the output register,
// from which its result is offered. The head entry and the owner count come
// from registered memory reads issued before execution, with write-through
// so back-to-back operations on the same slot or owner see fresh data. While a
// result waits in the output register, one more transaction is taken into the
// input register; the input then stalls until the waiting result is accepted.
`timescale 1ns / 1ps

module owner_checked_fifo (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata: operation[1:0], owner[8:2], value[72:9], zero fill[79:73]
    input  logic [ocf_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // Output stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: status[1:0], removed_value[65:2], owner_count[72:66], zero fill[79:73]
    output logic [ocf_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata
);
    import ocf_pkg::*;

    // Handshakes
    logic w_s_accept;
    logic w_advance;

    // Input register
    logic               r_in_valid;
    logic [OP_W-1:0]    r_op;
    logic [OWNER_W-1:0] r_owner;
    logic [VALUE_W-1:0] r_value;

    // Queue pointers
    logic [IDX_W-1:0] r_head, n_head;
    logic [IDX_W-1:0] r_tail, n_tail;
    logic [OCC_W-1:0] r_occ,  n_occ;

    // Output register
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [VALUE_W-1:0]  r_out_removed;
    logic [CNT_W-1:0]    r_out_count;

    // Execute results
    logic [STATUS_W-1:0] w_status;
    logic [VALUE_W-1:0]  w_removed;
    logic [CNT_W-1:0]    w_count;
    logic                w_push;
    logic                w_pop;

    // Store ports
    t_entry_wr          w_entry_wr;
    t_cnt_wr            w_cnt_wr;
    logic [OWNER_W-1:0] w_head_owner;
    logic [VALUE_W-1:0] w_head_value;
    logic [CNT_W-1:0]   w_cnt_rd;

    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign w_s_accept      = i_s_axis_tvalid && o_s_axis_tready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_op    <= i_s_axis_tdata[OP_W-1:0];
            r_owner <= i_s_axis_tdata[OP_W +: OWNER_W];
            r_value <= i_s_axis_tdata[OP_W + OWNER_W +: VALUE_W];
        end
    end

    // Execute: decide status and queue movement for the held transaction
    always_comb begin
        w_status  = ST_OK;
        w_removed = '0;
        w_push    = 1'b0;
        w_pop     = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                if (r_occ == OCC_W'(DEPTH)) begin
                    w_status = ST_FULL;
                end else begin
                    w_push = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (r_occ == '0) begin
                    w_status = ST_EMPTY;
                end else if (w_head_owner != r_owner) begin
                    w_status = ST_NOT_OWNER;
                end else begin
                    w_pop     = 1'b1;
                    w_removed = w_head_value;
                end
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Owner count after the operation
    always_comb begin
        w_count = w_cnt_rd;
        if (w_push) begin
            w_count = w_cnt_rd + 1'b1;
        end else if (w_pop && (w_cnt_rd != '0)) begin
            w_count = w_cnt_rd - 1'b1;
        end
    end

    // Pointer next values, committed only when the transaction moves on
    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        n_occ  = r_occ;
        if (w_advance && w_push) begin
            n_tail = f_next_slot(r_tail);
            n_occ  = r_occ + 1'b1;
        end else if (w_advance && w_pop) begin
            n_head = f_next_slot(r_head);
            n_occ  = r_occ - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_occ  <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_occ  <= n_occ;
        end
    end

    // Store writes
    always_comb begin
        w_entry_wr.en    = w_advance && w_push;
        w_entry_wr.addr  = r_tail;
        w_entry_wr.owner = r_owner;
        w_entry_wr.value = r_value;
        w_cnt_wr.en      = w_advance && (w_push || w_pop);
        w_cnt_wr.addr    = r_owner;
        w_cnt_wr.data    = w_count;
    end

    // Head entry is read at the next head so it is ready for the next transaction
    ocf_entry_store u_entry_store (
        .i_clk      (i_clk),
        .i_wr       (w_entry_wr),
        .i_rd_addr  (n_head),
        .o_rd_owner (w_head_owner),
        .o_rd_value (w_head_value)
    );

    // Owner count is read as the transaction enters the input register
    ocf_count_store u_count_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_s_accept),
        .i_rd_addr  (i_s_axis_tdata[OP_W +: OWNER_W]),
        .i_wr       (w_cnt_wr),
        .o_rd_count (w_cnt_rd)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_status  <= w_status;
            r_out_removed <= w_removed;
            r_out_count   <= w_count;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_DATA_W - OUT_FIELDS_W)'(0),
                              r_out_count, r_out_removed, r_out_status};

`ifndef SYNTHESIS
    // Occupancy never exceeds the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    // Equal pointers only when the queue is empty or full
    a_ptr_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head == r_tail) |-> ((r_occ == '0) || (r_occ == OCC_W'(DEPTH))))
        else $error("pointers and occupancy disagree");

    // A committed add grows the queue by one entry
    a_push_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_push) |=> (r_occ == $past(r_occ) + 1'b1))
        else $error("add did not grow occupancy");

    // A successful remove reports a non-full, non-empty status of ok
    a_pop_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_pop) |=> (r_out_status == ST_OK))
        else $error("remove committed with error status");
`endif

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the owner-checked FIFO: drives queue transactions
// on the input stream and compares every result against a shadow queue model.
// Depends on ocf_pkg and owner_checked_fifo from the src folder.
`timescale 1ns / 1ps

module testbench;
    import ocf_pkg::*;

    // Alternate query encoding, not named in the package
    localparam logic [OP_W-1:0] OP_QUERY_ALT = 2'd3;
    localparam int IDLE_LIMIT   = 5000;
    localparam int ITEM_TARGET  = 1100;
    localparam int HOLD_CYCLES  = 300;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX, MODE_NOISE} t_mode;

    typedef struct packed {
        logic [OWNER_W-1:0] owner;
        logic [VALUE_W-1:0] value;
    } t_slot;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  removed;
        logic [CNT_W-1:0]    count;
    } t_reply;

    // Shadow of the queue plus the replies it still owes
    class QueueScoreboard;
        t_slot            shadow_entries[$];
        logic [CNT_W-1:0] owner_tally[OWNERS];
        t_reply           due_replies[$];
        int               mismatches;
        int               replies_checked;
        int               status_seen[4];
        int               peak_fill;

        function new();
            foreach (owner_tally[i]) owner_tally[i] = '0;
            foreach (status_seen[i]) status_seen[i] = 0;
            mismatches      = 0;
            replies_checked = 0;
            peak_fill       = 0;
        endfunction

        function int fill_level();
            return shadow_entries.size();
        endfunction

        function logic [OWNER_W-1:0] head_owner();
            return shadow_entries[0].owner;
        endfunction

        function int outstanding();
            return due_replies.size();
        endfunction

        // Apply one accepted transaction to the shadow queue, queue its reply
        function void note_request(logic [OP_W-1:0] op, logic [OWNER_W-1:0] owner,
                                   logic [VALUE_W-1:0] value);
            t_reply r;
            t_slot  s;
            r.status  = ST_OK;
            r.removed = '0;
            if (op == OP_ADD) begin
                if (shadow_entries.size() >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s.owner = owner;
                    s.value = value;
                    shadow_entries.push_back(s);
                    owner_tally[owner] = owner_tally[owner] + 1'b1;
                end
            end else if (op == OP_REMOVE) begin
                if (shadow_entries.size() == 0) begin
                    r.status = ST_EMPTY;
                end else if (shadow_entries[0].owner != owner) begin
                    r.status = ST_NOT_OWNER;
                end else begin
                    r.removed = shadow_entries[0].value;
                    void'(shadow_entries.pop_front());
                    if (owner_tally[owner] != 0)
                        owner_tally[owner] = owner_tally[owner] - 1'b1;
                end
            end
            // query and the spare code leave the queue alone
            r.count = owner_tally[owner];
            due_replies.push_back(r);
            status_seen[r.status]++;
            if (shadow_entries.size() > peak_fill) peak_fill = shadow_entries.size();
        endfunction

        // Compare one accepted result with the oldest owed reply
        function void check_response(logic [OUT_DATA_W-1:0] data);
            t_reply exp_r;
            t_reply got;
            got.status  = data[STATUS_W-1:0];
            got.removed = data[STATUS_W +: VALUE_W];
            got.count   = data[STATUS_W + VALUE_W +: CNT_W];
            if (due_replies.size() == 0) begin
                $error("unexpected result: status %0d, removed_value 0x%016h, owner_count %0d",
                       got.status, got.removed, got.count);
                mismatches++;
                return;
            end
            exp_r = due_replies.pop_front();
            replies_checked++;
            if (got.status != exp_r.status) begin
                $error("status: expected %0d, got %0d", exp_r.status, got.status);
                mismatches++;
            end
            if (got.removed != exp_r.removed) begin
                $error("removed_value: expected 0x%016h, got 0x%016h",
                       exp_r.removed, got.removed);
                mismatches++;
            end
            if (got.count != exp_r.count) begin
                $error("owner_count: expected %0d, got %0d", exp_r.count, got.count);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OUT_DATA_W-1:0] m_data;

    QueueScoreboard        sb = new();
    logic [OWNER_W-1:0]    owner_pool[4];
    int                    items_sent = 0;
    int                    idle_cycles = 0;
    bit                    hold_done = 1'b0;

    owner_checked_fifo dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor both streams and watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_valid && s_ready)
                sb.note_request(s_data[OP_W-1:0], s_data[OP_W +: OWNER_W],
                                s_data[OP_W + OWNER_W +: VALUE_W]);
            if (m_valid && m_ready)
                sb.check_response(m_data);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [OWNER_W-1:0] pool_owner();
        if ($urandom_range(0, 99) < 75) return owner_pool[$urandom_range(0, 3)];
        return OWNER_W'($urandom_range(0, OWNERS - 1));
    endfunction

    // Owner that matches the head when there is one, most of the time
    function automatic logic [OWNER_W-1:0] head_or_pool(int odds);
        if (sb.fill_level() != 0 && $urandom_range(0, 99) < odds) return sb.head_owner();
        return pool_owner();
    endfunction

    // Offer one transaction at a falling edge and hold it until accepted
    task automatic send_op(input logic [OP_W-1:0] op, input logic [OWNER_W-1:0] owner,
                           input logic [VALUE_W-1:0] value, input int gap);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_data  = IN_DATA_W'({value, owner, op});
        s_valid = 1'b1;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        items_sent++;
    endtask

    // One burst of random traffic shaped by mode
    task automatic run_burst(input t_mode mode, input int len);
        int                 r;
        bit                 steady;
        logic [OP_W-1:0]    op;
        logic [OWNER_W-1:0] owner;
        steady = ($urandom_range(0, 3) == 0);
        foreach (owner_pool[i]) owner_pool[i] = OWNER_W'($urandom_range(0, OWNERS - 1));
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            case (mode)
                MODE_FILL: begin
                    op    = (r < 90) ? OP_ADD : OP_QUERY;
                    owner = pool_owner();
                end
                MODE_DRAIN: begin
                    op    = (r < 95) ? OP_REMOVE : OP_QUERY;
                    owner = (r < 85) ? head_or_pool(100) : pool_owner();
                end
                MODE_MIX: begin
                    if (r < 40) begin
                        op    = OP_ADD;
                        owner = pool_owner();
                    end else if (r < 70) begin
                        op    = OP_REMOVE;
                        owner = head_or_pool(90);
                    end else if (r < 80) begin
                        op    = OP_REMOVE;
                        owner = pool_owner();
                    end else begin
                        op    = (r < 95) ? OP_QUERY : OP_QUERY_ALT;
                        owner = pool_owner();
                    end
                end
                default: begin
                    op    = OP_W'($urandom_range(0, 3));
                    owner = OWNER_W'($urandom_range(0, OWNERS - 1));
                end
            endcase
            send_op(op, owner, rand_value(), steady ? 0 : pick_gap());
        end
    endtask

    // Result side: random stalls, plus one long hold-off mid-run
    initial begin
        int low;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!hold_done && sb.replies_checked >= 350) begin
                hold_done = 1'b1;
                m_ready   = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            low = pick_gap();
            if (low > 0) begin
                m_ready = 1'b0;
                repeat (low) @(negedge i_clk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(0, 23)) @(negedge i_clk);
        end
    end

    // Stimulus: directed corner cases, a fill past full and a drain, then random bursts
    initial begin
        int    r;
        t_mode mode;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_op(OP_QUERY, 7'd0, '0, 0);
        send_op(OP_QUERY_ALT, 7'd127, '1, 0);
        send_op(OP_REMOVE, 7'd5, '0, 0);                        // empty queue
        send_op(OP_ADD, 7'd0, '0, 0);
        send_op(OP_ADD, 7'd127, '1, 0);
        send_op(OP_ADD, 7'h55, 64'hAAAA_AAAA_AAAA_AAAA, 0);
        send_op(OP_ADD, 7'h2A, 64'h5555_5555_5555_5555, 0);
        send_op(OP_QUERY, 7'd127, '0, 0);
        send_op(OP_REMOVE, 7'd127, '0, 0);                      // foreign head
        send_op(OP_REMOVE, 7'd0, '1, 0);
        send_op(OP_REMOVE, 7'd0, '0, 0);                        // foreign head
        send_op(OP_REMOVE, 7'd127, '0, 0);
        send_op(OP_QUERY_ALT, 7'h55, '0, 0);
        send_op(OP_REMOVE, 7'h55, '0, 0);
        send_op(OP_REMOVE, 7'h2A, '0, 0);
        send_op(OP_REMOVE, 7'h2A, '0, 0);                       // empty again
        send_op(OP_ADD, 7'd3, 64'd1, 0);
        send_op(OP_ADD, 7'd3, 64'd2, 0);
        send_op(OP_REMOVE, 7'd3, '0, 0);
        send_op(OP_QUERY, 7'd3, '0, 0);
        send_op(OP_REMOVE, 7'd3, '0, 0);

        // past full, so the full status and index wrap are hit early
        run_burst(MODE_FILL, 75);
        run_burst(MODE_DRAIN, 70);

        while (items_sent < ITEM_TARGET) begin
            r = $urandom_range(0, 99);
            if (r < 25) mode = MODE_FILL;
            else if (r < 50) mode = MODE_DRAIN;
            else if (r < 85) mode = MODE_MIX;
            else mode = MODE_NOISE;
            run_burst(mode, $urandom_range(10, 80));
        end
        s_valid = 1'b0;

        // drain, then give late extra results a chance to show up
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d transactions: %0d ok, %0d empty, %0d not-owner, %0d full",
                 items_sent, sb.status_seen[ST_OK], sb.status_seen[ST_EMPTY],
                 sb.status_seen[ST_NOT_OWNER], sb.status_seen[ST_FULL]);
        $display("Queue peaked at %0d of %0d entries; %0d field mismatches",
                 sb.peak_fill, DEPTH, sb.mismatches);
        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
